### sv/chc_pkg.sv
// Shared types, constants and helper functions for the compass heading correction block.
package chc_pkg;

	localparam int NEGATE_ANGLE = 1;
	localparam int CORDIC_STEPS = 16;
	localparam int CAL_POINTS   = 8;
	localparam int RING_LEN     = CAL_POINTS + 2;

	localparam int CW        = 27;  // CORDIC datapath width
	localparam int FRAC_BITS = 16;  // fraction bits of the angle
	localparam int ANG_W     = 9;   // whole-degree angle
	localparam int DW        = 10;  // signed degree difference
	localparam int NUM_W     = 18;  // magnitude of the interpolation numerator
	localparam int DVW       = 8;   // magnitude of the segment width
	localparam int DIV_BITS  = 3;   // quotient bits per divider stage
	localparam int DIV_STAGES = NUM_W / DIV_BITS;
	localparam int QQ_W      = 10;  // quotient of a value by 360
	localparam int RECIP_SHIFT = 26;
	localparam logic [NUM_W-1:0] RECIP_360 = NUM_W'(186414);  // ceil(2^26 / 360)

	typedef logic signed [CW-1:0] cval_t;
	typedef logic [ANG_W-1:0]     ang_t;
	typedef logic signed [DW-1:0] diff_t;

	typedef struct packed {
		logic signed [15:0] field_x;
		logic signed [15:0] field_y;
	} in_item_t;

	typedef struct packed {
		logic [8:0] heading_deg;
		logic       corrected;
	} out_item_t;

	// control that rides along with the divider
	typedef struct packed {
		ang_t raw;      // uncorrected angle
		logic use_cal;  // a segment applies
		logic neg;      // quotient is negative
	} div_ctl_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic cval_t atan_tab(input int i);
		cval_t t;
		unique case (i)
			0:  t = cval_t'(2949120);
			1:  t = cval_t'(1740967);
			2:  t = cval_t'(919879);
			3:  t = cval_t'(466945);
			4:  t = cval_t'(234379);
			5:  t = cval_t'(117304);
			6:  t = cval_t'(58666);
			7:  t = cval_t'(29335);
			8:  t = cval_t'(14668);
			9:  t = cval_t'(7334);
			10: t = cval_t'(3667);
			11: t = cval_t'(1833);
			12: t = cval_t'(917);
			13: t = cval_t'(458);
			14: t = cval_t'(229);
			15: t = cval_t'(115);
			16: t = cval_t'(57);
			17: t = cval_t'(29);
			18: t = cval_t'(14);
			19: t = cval_t'(7);
			20: t = cval_t'(4);
			21: t = cval_t'(2);
			22: t = cval_t'(1);
			default: t = '0;
		endcase
		return t;
	endfunction

	// true heading at each ring point
	function automatic diff_t true_angle(input int p);
		diff_t t;
		unique case (p)
			0: t = diff_t'(315);
			1: t = diff_t'(0);
			2: t = diff_t'(45);
			3: t = diff_t'(90);
			4: t = diff_t'(135);
			5: t = diff_t'(180);
			6: t = diff_t'(225);
			7: t = diff_t'(270);
			8: t = diff_t'(315);
			default: t = diff_t'(0);
		endcase
		return t;
	endfunction

	// a - b folded into -180..180
	function automatic diff_t wrap_diff(input diff_t a, input diff_t b);
		diff_t d;
		d = a - b;
		if (d > diff_t'(180))
			d = d - diff_t'(360);
		else if (d < diff_t'(-180))
			d = d + diff_t'(360);
		return d;
	endfunction

endpackage

### sv/chc_cordic.sv
// Pipelined CORDIC vectoring unit: field sample to whole-degree angle 0..359.
module chc_cordic
	import chc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t item,
	output logic     out_valid,
	output ang_t     angle
);

	localparam cval_t Z180 = cval_t'(180 * 65536);
	localparam cval_t Z90  = cval_t'(90 * 65536);

	cval_t x_s    [CORDIC_STEPS+1];
	cval_t y_s    [CORDIC_STEPS+1];
	cval_t z_s    [CORDIC_STEPS+1];
	logic  hold_s [CORDIC_STEPS+1];
	logic  v_s    [CORDIC_STEPS+1];

	cval_t xe, ye, x0, y0, z0;
	logic  hold0;

	// axis samples are exact; left half-plane is turned by 180 first
	always_comb begin
		xe    = cval_t'(item.field_y) <<< 8;
		ye    = cval_t'(item.field_x) <<< 8;
		x0    = xe;
		y0    = ye;
		z0    = '0;
		hold0 = 1'b0;
		if (item.field_x == 16'sd0) begin
			hold0 = 1'b1;
			z0    = (item.field_y < 16'sd0) ? Z180 : '0;
		end else if (item.field_y == 16'sd0) begin
			hold0 = 1'b1;
			z0    = (item.field_x > 16'sd0) ? Z90 : -Z90;
		end else if (xe < 0) begin
			x0 = -xe;
			y0 = -ye;
			z0 = (ye > 0) ? Z180 : -Z180;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= x0;
		y_s[0]    <= y0;
		z_s[0]    <= z0;
		hold_s[0] <= hold0;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			hold_s[i+1] <= hold_s[i];
			if (hold_s[i]) begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				z_s[i+1] <= z_s[i];
			end else if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_tab(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_tab(i);
			end
		end
	end

	// negate, truncate toward zero to whole degrees, wrap
	cval_t                      zn;
	logic [CW-1:0]              zmag;
	logic [CW-FRAC_BITS-1:0]    dmag;
	logic signed [CW-FRAC_BITS:0] deg, degw;

	always_comb begin
		zn   = (NEGATE_ANGLE != 0) ? -z_s[CORDIC_STEPS] : z_s[CORDIC_STEPS];
		zmag = (zn < 0) ? -zn : zn;
		dmag = zmag[CW-1:FRAC_BITS];
		deg  = (zn < 0) ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
		if (deg < 0)
			degw = deg + (CW-FRAC_BITS+1)'(360);
		else if (deg >= (CW-FRAC_BITS+1)'(360))
			degw = deg - (CW-FRAC_BITS+1)'(360);
		else
			degw = deg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= v_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		angle <= degw[ANG_W-1:0];
	end

endmodule

### sv/chc_seg.sv
// Segment search and interpolation numerator over the calibration ring.
module chc_seg
	import chc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  ang_t             angle,
	input  ang_t             ring [RING_LEN],
	output logic             out_valid,
	output logic [NUM_W-1:0] num_mag,
	output logic [DVW-1:0]   dvsr,
	output div_ctl_t         ctl
);

	// stage 1: first segment holding the angle
	diff_t fd, n1, n2, w, a1, a2, rp, rq, m1, m2;
	logic  found;

	always_comb begin
		fd    = diff_t'({1'b0, angle});
		found = 1'b0;
		n1    = '0;
		n2    = '0;
		w     = '0;
		a1    = '0;
		a2    = '0;
		for (int p = RING_LEN - 2; p >= 0; p--) begin
			rp = diff_t'({1'b0, ring[p]});
			rq = diff_t'({1'b0, ring[p+1]});
			m2 = wrap_diff(fd, rp);
			m1 = wrap_diff(fd, rq);
			if (m2 >= 0 && m1 <= 0) begin
				found = 1'b1;
				n1    = m1;
				n2    = m2;
				w     = wrap_diff(rp, rq);
				a1    = wrap_diff(true_angle(p), rp);
				a2    = wrap_diff(true_angle(p + 1), rq);
			end
		end
	end

	logic  v_s1, found_s1;
	ang_t  f_s1;
	diff_t n1_s1, n2_s1, w_s1, a1_s1, a2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		f_s1     <= angle;
		found_s1 <= found;
		n1_s1    <= n1;
		n2_s1    <= n2;
		w_s1     <= w;
		a1_s1    <= a1;
		a2_s1    <= a2;
	end

	// stage 2: products
	logic                   v_s2, use_s2;
	ang_t                   f_s2;
	diff_t                  w_s2;
	logic signed [2*DW-1:0] pf_s2, p1_s2, p2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		f_s2   <= f_s1;
		w_s2   <= w_s1;
		use_s2 <= found_s1 && (w_s1 != '0);
		pf_s2  <= diff_t'({1'b0, f_s1}) * w_s1;
		p1_s2  <= a1_s1 * n1_s1;
		p2_s2  <= a2_s1 * n2_s1;
	end

	// stage 3: numerator, magnitudes and quotient sign
	logic signed [2*DW:0] num;
	logic [2*DW:0]        nmag;
	diff_t                wmag;

	always_comb begin
		num  = (2*DW+1)'(pf_s2) + (2*DW+1)'(p1_s2) - (2*DW+1)'(p2_s2);
		nmag = (num < 0) ? -num : num;
		wmag = (w_s2 < 0) ? -w_s2 : w_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= v_s2;
	end

	always_ff @(posedge clk) begin
		num_mag     <= nmag[NUM_W-1:0];
		dvsr        <= use_s2 ? wmag[DVW-1:0] : DVW'(1);
		ctl.raw     <= f_s2;
		ctl.use_cal <= use_s2;
		ctl.neg     <= num[2*DW] ^ w_s2[DW-1];
	end

endmodule

### sv/chc_div.sv
// Pipelined restoring divider, reduction modulo 360 and result register.
module chc_div
	import chc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_mag,
	input  logic [DVW-1:0]   dvsr,
	input  div_ctl_t         ctl,
	output logic             done,
	output out_item_t        result
);

	logic [DVW-1:0]   rem_s [DIV_STAGES+1];
	logic [NUM_W-1:0] dnd_s [DIV_STAGES+1];
	logic [NUM_W-1:0] quo_s [DIV_STAGES+1];
	logic [DVW-1:0]   dv_s  [DIV_STAGES+1];
	div_ctl_t         ctl_s [DIV_STAGES+1];
	logic             v_s   [DIV_STAGES+1];

	always_comb begin
		rem_s[0] = '0;
		dnd_s[0] = num_mag;
		quo_s[0] = '0;
		dv_s[0]  = dvsr;
		ctl_s[0] = ctl;
		v_s[0]   = in_valid;
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic [DVW-1:0]   r;
		logic [DVW:0]     t;
		logic [NUM_W-1:0] n, q;

		always_comb begin
			r = rem_s[j];
			n = dnd_s[j];
			q = quo_s[j];
			for (int b = 0; b < DIV_BITS; b++) begin
				t = {r, n[NUM_W-1]};
				n = n << 1;
				if (t >= {1'b0, dv_s[j]}) begin
					t = t - {1'b0, dv_s[j]};
					q = {q[NUM_W-2:0], 1'b1};
				end else begin
					q = {q[NUM_W-2:0], 1'b0};
				end
				r = t[DVW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j+1] <= 1'b0;
			else
				v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= r;
			dnd_s[j+1] <= n;
			quo_s[j+1] <= q;
			dv_s[j+1]  <= dv_s[j];
			ctl_s[j+1] <= ctl_s[j];
		end
	end

	// quotient by 360 through the reciprocal
	logic [2*NUM_W-1:0] prod;
	logic               v_m1;
	logic [QQ_W-1:0]    qq_m1;
	logic [NUM_W-1:0]   t_m1;
	div_ctl_t           ctl_m1;

	assign prod = quo_s[DIV_STAGES] * RECIP_360;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_m1 <= 1'b0;
		else
			v_m1 <= v_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		qq_m1  <= prod[RECIP_SHIFT +: QQ_W];
		t_m1   <= quo_s[DIV_STAGES];
		ctl_m1 <= ctl_s[DIV_STAGES];
	end

	// remainder
	logic [NUM_W:0] rr;
	logic           v_m2;
	ang_t           r_m2;
	div_ctl_t       ctl_m2;

	always_comb begin
		rr = {1'b0, t_m1} - (NUM_W+1)'(qq_m1) * (NUM_W+1)'(360);
		if (rr >= (NUM_W+1)'(360))
			rr = rr - (NUM_W+1)'(360);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_m2 <= 1'b0;
		else
			v_m2 <= v_m1;
	end

	always_ff @(posedge clk) begin
		r_m2   <= rr[ANG_W-1:0];
		ctl_m2 <= ctl_m1;
	end

	// sign fixup and raw fallback
	ang_t hd;

	always_comb begin
		if (!ctl_m2.use_cal)
			hd = ctl_m2.raw;
		else if (ctl_m2.neg && r_m2 != '0)
			hd = ANG_W'(360) - r_m2;
		else
			hd = r_m2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v_m2;
	end

	always_ff @(posedge clk) begin
		result.heading_deg <= hd;
		result.corrected   <= ctl_m2.use_cal;
	end

endmodule

### sv/compass_heading_correction.sv
// Top level: calibration registers, CORDIC, segment search and divider pipeline.
//
// Usage:
//   Input channel: drive item (field_x, field_y) and raise start; the transfer
//   happens at any rising edge with start high, since busy is held low. One
//   sample can be taken every cycle.
//   Result channel: done strobes for one cycle with result (heading_deg,
//   corrected); the transfer completes at the edge that ends that cycle. The
//   receiver cannot hold results off and none is needed: every stage advances
//   every cycle.
//   Pipeline: one input stage, one stage per CORDIC step, angle rounding,
//   segment search, products, numerator, six divider stages of three quotient
//   bits each, and three stages to reduce modulo 360 and register the result.
//   Throughput: one item per cycle.
//   Configuration: APB port, calibration point k at byte address 4*k, data in
//   bits 8:0. Write only while the pipeline is empty; the block has no check.
//   Reset: pipeline valid bits clear; calibration registers return to
//   0, 45, ..., 315.
module compass_heading_correction
	import chc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ang_t cal_q [CAL_POINTS];
	ang_t cal_w [CAL_POINTS];
	ang_t ring  [RING_LEN];

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CAL_POINTS; k++)
				cal_q[k] <= ANG_W'(45 * k);
		end else if (psel && penable && pwrite && pready) begin
			cal_q[paddr[4:2]] <= pwdata[ANG_W-1:0];
		end
	end

	assign prdata = {{(32-ANG_W){1'b0}}, cal_q[paddr[4:2]]};

	// values 360..511 fold down; ring wraps at both ends
	always_comb begin
		for (int k = 0; k < CAL_POINTS; k++)
			cal_w[k] = (cal_q[k] >= ANG_W'(360)) ? cal_q[k] - ANG_W'(360) : cal_q[k];
		ring[0] = cal_w[CAL_POINTS-1];
		for (int k = 0; k < CAL_POINTS; k++)
			ring[k+1] = cal_w[k];
		ring[RING_LEN-1] = cal_w[0];
	end

	logic             ang_valid;
	ang_t             angle;
	logic             seg_valid;
	logic [NUM_W-1:0] num_mag;
	logic [DVW-1:0]   dvsr;
	div_ctl_t         ctl;

	chc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.item      (item),
		.out_valid (ang_valid),
		.angle     (angle)
	);

	chc_seg u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ang_valid),
		.angle     (angle),
		.ring      (ring),
		.out_valid (seg_valid),
		.num_mag   (num_mag),
		.dvsr      (dvsr),
		.ctl       (ctl)
	);

	chc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (seg_valid),
		.num_mag  (num_mag),
		.dvsr     (dvsr),
		.ctl      (ctl),
		.done     (done),
		.result   (result)
	);

endmodule

### sim/tb.sv
// Self-checking testbench for compass_heading_correction.
module tb;
	import chc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = CORDIC_STEPS + 20;
	localparam int ITEMS_PER_SET  = 250;

	// atan(2^-i) in degrees, 16 fraction bits
	localparam longint ATAN_DEG[24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};
	// true heading at each point of the segment ring
	localparam int RING_TRUE[10] = '{315, 0, 45, 90, 135, 180, 225, 270, 315, 0};

	typedef struct {
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		bit                 typed;   // expected value given in the row
		logic [8:0]         heading;
		logic               corr;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        done;
	out_item_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// typed expectation riding along with the item
	logic        row_typed = 1'b0;
	out_item_t   row_expect = '0;

	logic [8:0]  cal_shadow[CAL_POINTS];
	out_item_t   heading_queue[$];
	int          err_count = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_corrected = 0;
	int          n_settings = 0;
	int          idle_cycles = 0;

	compass_heading_correction dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int fold180(input int a, input int b);
		int d;
		d = a - b;
		if (d > 180)
			d -= 360;
		else if (d < -180)
			d += 360;
		return d;
	endfunction

	function automatic int mod360(input longint v);
		longint r;
		r = v % 360;
		if (r < 0)
			r += 360;
		return int'(r);
	endfunction

	// field angle, calibration ring search and linear interpolation
	function automatic out_item_t predict_heading(input logic signed [15:0] fx,
			input logic signed [15:0] fy, input logic [8:0] cal[CAL_POINTS]);
		longint x, y, z, xn, yn, num;
		int f, n1, n2, w, a1, a2, v;
		int ring[10];
		out_item_t r;
		z = 0;
		if (fx == 0)
			z = (fy < 0) ? 180 * 65536 : 0;
		else if (fy == 0)
			z = (fx > 0) ? 90 * 65536 : -90 * 65536;
		else begin
			x = longint'(fy) * 256;
			y = longint'(fx) * 256;
			if (x < 0) begin
				z = (y > 0) ? 180 * 65536 : -180 * 65536;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				if (y >= 0) begin
					xn = x + (y >>> i);
					yn = y - (x >>> i);
					z += ATAN_DEG[i];
				end else begin
					xn = x - (y >>> i);
					yn = y + (x >>> i);
					z -= ATAN_DEG[i];
				end
				x = xn;
				y = yn;
			end
		end
		if (NEGATE_ANGLE != 0)
			z = -z;
		f = mod360(z / 65536);
		for (int k = 0; k < 10; k++) begin
			v = cal[(k + 7) % 8];
			ring[k] = (v >= 360) ? v - 360 : v;
		end
		r.heading_deg = 9'(f);
		r.corrected = 1'b0;
		for (int p = 0; p < 9; p++) begin
			n2 = fold180(f, ring[p]);
			n1 = fold180(f, ring[p + 1]);
			if (n2 >= 0 && n1 <= 0) begin
				w = fold180(ring[p], ring[p + 1]);
				if (w != 0) begin
					a1 = fold180(RING_TRUE[p], ring[p]);
					a2 = fold180(RING_TRUE[p + 1], ring[p + 1]);
					num = longint'(f) * w + longint'(a1) * n1 - longint'(a2) * n2;
					r.heading_deg = 9'(mod360(num / w));
					r.corrected = 1'b1;
				end
				break;
			end
		end
		return r;
	endfunction

	// Monitor: transfers in, results out, register writes, all sampled at the edge.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				if (paddr[4:2] < CAL_POINTS)
					cal_shadow[paddr[4:2]] <= pwdata[8:0];
			if (start && !busy) begin
				if (row_typed)
					heading_queue.push_back(row_expect);
				else
					heading_queue.push_back(predict_heading(item.field_x, item.field_y,
						cal_shadow));
			end
			if (done) begin
				if (heading_queue.size() == 0) begin
					$error("result with no expectation: heading_deg=%0d corrected=%0d",
						result.heading_deg, result.corrected);
					err_count++;
				end else begin
					want = heading_queue.pop_front();
					n_checked++;
					if (result.corrected)
						n_corrected++;
					if (result.heading_deg !== want.heading_deg) begin
						$error("heading_deg: expected %0d, got %0d",
							want.heading_deg, result.heading_deg);
						err_count++;
					end
					if (result.corrected !== want.corrected) begin
						$error("corrected: expected %0d, got %0d",
							want.corrected, result.corrected);
						err_count++;
					end
				end
			end
			// watchdog: cycles with no transfer on either side
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: %0d cycles with no transfer", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// APB write: setup cycle, then access cycle; pready is always high
	task automatic apb_write(input int k, input logic [8:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * k);
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// back-to-back writes; the bus goes idle after the last one
	task automatic load_cal(input logic [8:0] v[CAL_POINTS]);
		for (int k = 0; k < CAL_POINTS; k++)
			apb_write(k, v[k]);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	// hold start high until the transfer; sometimes drop into a gap afterwards
	task automatic send_sample(input logic signed [15:0] fx, input logic signed [15:0] fy,
			input bit typed, input out_item_t want);
		start <= 1'b1;
		item <= '{field_x: fx, field_y: fy};
		row_typed <= typed;
		row_expect <= want;
		do
			@(posedge clk);
		while (busy);
		n_sent++;
		if ($urandom_range(0, 9) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 16'sd0;
			1: return 16'sh8000;
			2: return 16'sh7fff;
			3: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (heading_queue.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic random_samples(input int count);
		for (int i = 0; i < count; i++)
			send_sample(pick_field(), pick_field(), 1'b0, '0);
	endtask

	stim_row_t directed[$];
	logic [8:0] cal_set[CAL_POINTS];

	initial begin
		for (int k = 0; k < CAL_POINTS; k++)
			cal_shadow[k] = 9'(45 * k);
		// axis samples under ideal calibration map straight through
		directed = '{
			'{16'sd0, 16'sd0, 1'b1, 9'd0, 1'b1},
			'{16'sd0, 16'sd100, 1'b1, 9'd0, 1'b1},
			'{16'sd0, -16'sd100, 1'b1, 9'd180, 1'b1},
			'{16'sd0, 16'sh8000, 1'b1, 9'd180, 1'b1},
			'{16'sd5, 16'sd0, 1'b1, 9'd270, 1'b1},
			'{16'sh7fff, 16'sd0, 1'b1, 9'd270, 1'b1},
			'{-16'sd5, 16'sd0, 1'b1, 9'd90, 1'b1},
			'{16'sh8000, 16'sd0, 1'b1, 9'd90, 1'b1},
			'{16'sh7fff, 16'sh7fff, 1'b0, 9'd0, 1'b0},
			'{16'sh8000, 16'sh8000, 1'b0, 9'd0, 1'b0},
			'{16'sh7fff, 16'sh8000, 1'b0, 9'd0, 1'b0},
			'{16'sh8000, 16'sh7fff, 1'b0, 9'd0, 1'b0},
			'{16'sd1, -16'sd1, 1'b0, 9'd0, 1'b0},
			'{-16'sd1, -16'sd1, 1'b0, 9'd0, 1'b0},
			'{16'sd1, 16'sh7fff, 1'b0, 9'd0, 1'b0},
			'{-16'sd1, 16'sh8000, 1'b0, 9'd0, 1'b0},
			'{16'sd1, 16'sh8000, 1'b0, 9'd0, 1'b0},
			'{16'sd300, 16'sd519, 1'b0, 9'd0, 1'b0},
			'{-16'sd1234, 16'sd4321, 1'b0, 9'd0, 1'b0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_sample(directed[i].fx, directed[i].fy, directed[i].typed,
				'{heading_deg: directed[i].heading, corrected: directed[i].corr});
		random_samples(ITEMS_PER_SET);
		wait_drained();

		// calibration sets: zero-width and unmatched segments, extremes, out-of-range
		// register values, near-ideal, then fully random
		for (int s = 0; s < 7; s++) begin
			for (int k = 0; k < CAL_POINTS; k++)
				case (s)
					0: cal_set[k] = 9'd100;
					1: cal_set[k] = 9'd0;
					2: cal_set[k] = 9'd359;
					3: cal_set[k] = 9'd511;
					4: cal_set[k] = 9'(45 * k + $urandom_range(0, 40) - 20 + 360);
					5: cal_set[k] = 9'(((45 * k + 360) % 360) + $urandom_range(0, 60));
					default: cal_set[k] = 9'($urandom_range(0, 511));
				endcase
			load_cal(cal_set);
			// exact-angle hits on the zero-width set
			if (s == 0) begin
				send_sample(16'sd0, 16'sd50, 1'b0, '0);
				send_sample(-16'sd50, 16'sd0, 1'b0, '0);
			end
			random_samples(ITEMS_PER_SET);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d samples over %0d calibration sets, %0d results checked",
			n_sent, n_settings + 1, n_checked);
		$display("%0d results used a calibration segment", n_corrected);
		if (err_count == 0 && heading_queue.size() == 0)
			$display("*** PASSED ***");
		else begin
			if (heading_queue.size() != 0)
				$error("%0d expected results never arrived", heading_queue.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
